[rtl/ntcu_pkg.sv]
// Package for the numeric type cast unit: type codes and conversion helpers.
// No dependencies.
package ntcu_pkg;

  localparam logic [3:0] TypeI8  = 4'd0;
  localparam logic [3:0] TypeI16 = 4'd1;
  localparam logic [3:0] TypeI32 = 4'd2;
  localparam logic [3:0] TypeI64 = 4'd3;
  localparam logic [3:0] TypeU8  = 4'd4;
  localparam logic [3:0] TypeU16 = 4'd5;
  localparam logic [3:0] TypeU32 = 4'd6;
  localparam logic [3:0] TypeU64 = 4'd7;
  localparam logic [3:0] TypeF32 = 4'd8;
  localparam logic [3:0] TypeF64 = 4'd9;
  localparam logic [3:0] TypeC64 = 4'd10;
  localparam logic [3:0] TypeC128 = 4'd11;

  localparam logic RegSourceType = 1'b0;
  localparam logic RegDestType   = 1'b1;

  typedef struct packed {
    logic [63:0] source_value;
    logic [63:0] source_high;
    logic        last_element;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [63:0] result_high;
    logic        written;
    logic        last_out;
  } out_item_t;

  // Mask for the element width of a type code.
  function automatic logic [63:0] type_mask(logic [3:0] t);
    logic [63:0] m;
    m = '1;
    if (t < 4'd8) begin
      unique case (t[1:0])
        2'd0: m = 64'h0000_0000_0000_00FF;
        2'd1: m = 64'h0000_0000_0000_FFFF;
        2'd2: m = 64'h0000_0000_FFFF_FFFF;
        default: m = '1;
      endcase
    end else if (t == TypeF32) begin
      m = 64'h0000_0000_FFFF_FFFF;
    end
    return m;
  endfunction

  // float32 to float64 bits, exact; NaN quieted with payload kept.
  function automatic logic [63:0] f32_widen(logic [31:0] b);
    logic [7:0]  e;
    logic [22:0] f;
    logic [63:0] r;
    logic [4:0]  lz;
    logic [22:0] fn;
    e  = b[30:23];
    f  = b[22:0];
    r  = {b[31], 63'd0};
    lz = 5'd0;
    fn = '0;
    if (e == 8'hFF) begin
      r = {b[31], 11'h7FF, (f != 23'd0), f[21:0], 29'd0};
    end else if (e != 8'd0) begin
      r = {b[31], 3'd0 + {3'd0, e} + 11'd896, f, 29'd0};
    end else if (f != 23'd0) begin
      // subnormal: normalize by the leading one
      for (int i = 0; i < 23; i++) begin
        if (f[i]) lz = 5'(22 - i);
      end
      fn = f << (lz + 5'd1);
      r  = {b[31], 11'(11'd896 - {6'd0, lz}), fn, 29'd0};
    end
    return r;
  endfunction

  // Small signed integer to float64 bits (exact).
  function automatic logic [63:0] int_to_f64(logic signed [16:0] v);
    logic [16:0] a;
    logic [4:0]  p;
    logic [51:0] fr;
    a = v[16] ? 17'(-v) : 17'(v);
    p = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (a[i]) p = 5'(i);
    end
    fr = {35'd0, a} << (6'd52 - {1'b0, p});
    if (a == 17'd0) return 64'd0;
    return {v[16], 11'(11'd1023 + {6'd0, p}), fr};
  endfunction

  // Small signed integer to float32 bits (exact for 16-bit values).
  function automatic logic [31:0] int_to_f32(logic signed [16:0] v);
    logic [63:0] d;
    d = int_to_f64(v);
    if (d[62:0] == 63'd0) return {d[63], 31'd0};
    return {d[63], 8'(d[62:52] - 11'd896), d[51:29]};
  endfunction

  // float32 bits to integer type t, truncate toward zero with saturation.
  function automatic logic [63:0] f32_to_int(logic [31:0] b, logic [3:0] t);
    logic [7:0]   e;
    logic [63:0]  mag;
    logic [87:0]  wide;
    logic [6:0]   n;
    logic         sgn;
    logic [63:0]  hi;
    logic [63:0]  m;
    logic [63:0]  r;
    logic         big;
    e    = b[30:23];
    sgn  = b[31];
    m    = type_mask(t);
    n    = 7'd8 << t[1:0];
    mag  = '0;
    wide = '0;
    big  = 1'b0;
    if (e == 8'hFF) begin
      big = 1'b1;
    end else if (e >= 8'd127) begin
      if (e >= 8'd127 + 8'd64) big = 1'b1;
      else begin
        // integer part: leading one lands at most at bit 86
        wide = {64'd0, 1'b1, b[22:0]} << (e - 8'd127);
        mag  = wide[86:23];
      end
    end
    if (e == 8'hFF && b[22:0] != 23'd0) return 64'd0;
    if (!t[2]) begin
      hi = m >> 1;
      if (!sgn) r = (big || mag > hi) ? hi : mag;
      else r = (big || mag > hi + 64'd1) ? ((~hi) & m) : ((64'd0 - mag) & m);
    end else begin
      if (sgn) r = 64'd0;
      else r = (big || (n != 7'd64 && (mag >> n[5:0]) != 64'd0)) ? m : mag;
    end
    return r;
  endfunction

endpackage

[rtl/ntcu_stream_if.sv]
// Valid/ready stream interface carrying one item of type T.
// Depends on nothing.
interface ntcu_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/ntcu_convert.sv]
// Combinational conversion of one element between the configured types.
// Depends on ntcu_pkg.
module ntcu_convert (
  input  logic [3:0]         src_type_i,
  input  logic [3:0]         dst_type_i,
  input  ntcu_pkg::in_item_t in_i,
  output ntcu_pkg::out_item_t out_o
);
  import ntcu_pkg::*;

  logic signed [16:0] sv;
  logic [63:0] rv, rh;
  logic        wr;
  logic [63:0] x;

  assign x  = in_i.source_value;
  assign sv = (src_type_i == TypeI8) ? 17'(signed'(x[7:0])) : 17'(signed'(x[15:0]));

  always_comb begin
    rv = '0;
    rh = '0;
    wr = 1'b0;
    if (src_type_i == dst_type_i) begin
      if (src_type_i <= TypeC128) begin
        rv = x & type_mask(src_type_i);
        if (src_type_i == TypeC128) rh = in_i.source_high;
        wr = 1'b1;
      end
    end else if (src_type_i == TypeI8 || src_type_i == TypeI16) begin
      wr = 1'b1;
      if (dst_type_i < TypeF32) rv = 64'(sv) & type_mask(dst_type_i);
      else if (dst_type_i == TypeF32 || dst_type_i == TypeC64) rv = {32'd0, int_to_f32(sv)};
      else if (dst_type_i == TypeF64 || dst_type_i == TypeC128) rv = int_to_f64(sv);
      else wr = 1'b0;
    end else if (src_type_i == TypeF32) begin
      wr = 1'b1;
      if (dst_type_i < TypeF32) rv = f32_to_int(x[31:0], dst_type_i);
      else if (dst_type_i == TypeF64 || dst_type_i == TypeC128) rv = f32_widen(x[31:0]);
      else if (dst_type_i == TypeC64) rv = {32'd0, x[31:0]};
      else wr = 1'b0;
    end else if (src_type_i == TypeC64) begin
      wr = 1'b1;
      if (dst_type_i == TypeF32) rv = {32'd0, x[31:0]};
      else if (dst_type_i == TypeF64) rv = f32_widen(x[31:0]);
      else if (dst_type_i == TypeC128) begin
        rv = f32_widen(x[31:0]);
        rh = f32_widen(x[63:32]);
      end else wr = 1'b0;
    end
  end

  assign out_o = '{result_value: rv, result_high: rh, written: wr,
                   last_out: in_i.last_element};
endmodule

[rtl/numeric_type_cast_unit_core.sv]
// Top level of the numeric type cast unit: input register, converter,
// output register. Depends on ntcu_pkg, ntcu_stream_if and ntcu_convert.
//
// Usage: write source_type (index 0) and dest_type (index 1) through the
// cfg port while idle; both reset to int8. Items enter on in_s and leave
// on out_s with valid/ready handshakes. An accepted item is held in the
// input register, converted by one stage of combinational logic and
// placed in the output register, where it stays valid until taken. One
// item per cycle is sustained while out_s stays ready; the pipeline
// advances whenever its output stage is empty or being taken, so a stall
// on out_s backs up through both registers and drops ready on in_s only
// when both are full. Reset empties both stages.
module numeric_type_cast_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  ntcu_stream_if.sink   in_s,
  ntcu_stream_if.source out_s
);
  import ntcu_pkg::*;

  logic [3:0] src_type_q, dst_type_q;
  logic       in_vld_q, out_vld_q;
  in_item_t   in_q;
  out_item_t  out_q, conv;
  logic       adv_out, adv_in;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_type_q <= TypeI8;
      dst_type_q <= TypeI8;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegSourceType) src_type_q <= cfg_data_i;
      else dst_type_q <= cfg_data_i;
    end
  end

  assign adv_out = !out_vld_q || out_s.ready;
  assign adv_in  = !in_vld_q || adv_out;
  assign in_s.ready = adv_in;

  ntcu_convert u_convert (
    .src_type_i(src_type_q),
    .dst_type_i(dst_type_q),
    .in_i(in_q),
    .out_o(conv)
  );

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_in) in_vld_q <= in_s.valid;
      if (adv_out) out_vld_q <= in_vld_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv_in && in_s.valid) in_q <= in_s.data;
    if (adv_out && in_vld_q) out_q <= conv;
  end

  assign out_s.valid = out_vld_q;
  assign out_s.data  = out_q;
endmodule

[rtl/ntcu_checker.sv]
// Port-level checker for numeric_type_cast_unit_core, with its bind.
// Depends on ntcu_pkg.
module ntcu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input ntcu_pkg::out_item_t out_data
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // input ready whenever output is being drained
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready |-> in_ready) else $error("ready low while draining");
  // nothing appears without an earlier accepted item
  a_orig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without item");
  // unwritten result carries zero data
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.written |-> out_data.result_value == 64'd0 &&
    out_data.result_high == 64'd0) else $error("unwritten result nonzero");
endmodule

bind numeric_type_cast_unit_core ntcu_checker u_ntcu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_s.valid), .in_ready(in_s.ready),
  .out_valid(out_s.valid), .out_ready(out_s.ready), .out_data(out_s.data)
);

[dv/ntcu_cast_checker.sv]
`timescale 1ns / 1ps
// Checker for the numeric type cast unit: tracks the config port, predicts each
// converted element and compares it with the output stream. Depends on ntcu_pkg.
module ntcu_cast_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ntcu_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ntcu_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);
  import ntcu_pkg::*;

  logic [3:0] src_type;
  logic [3:0] dst_type;
  out_item_t  expected_q[$];

  // Mask of the element width of a type code
  function automatic logic [63:0] width_mask(logic [3:0] t);
    if (t < TypeF32) begin
      case (t[1:0])
        2'd0: return 64'hFF;
        2'd1: return 64'hFFFF;
        2'd2: return 64'hFFFF_FFFF;
        default: return '1;
      endcase
    end
    if (t == TypeF32) return 64'hFFFF_FFFF;
    return '1;
  endfunction

  // Single to double precision, bit exact; NaN gets the quiet bit
  function automatic logic [63:0] single_to_double(logic [31:0] b);
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [63:0] sh;
    int          k;
    ex = b[30:23];
    fr = b[22:0];
    k  = 0;
    if (ex == 8'hFF)
      return {b[31], 11'h7FF, {fr, 29'd0} | ((fr != 0) ? 52'h8_0000_0000_0000 : 52'd0)};
    if (ex != 8'd0) return {b[31], 11'(ex) + 11'd896, fr, 29'd0};
    if (fr == 23'd0) return {b[31], 63'd0};
    // subnormal: msb of the fraction sets the exponent
    for (int i = 0; i < 23; i++) if (fr[i]) k = i;
    sh = {41'd0, fr} << (52 - k);
    return {b[31], 11'(k + 874), sh[51:0]};
  endfunction

  // Single to integer: truncate toward zero, saturate, NaN gives zero
  function automatic logic [63:0] single_to_integer(logic [31:0] b, logic [3:0] t);
    logic [63:0] m;
    logic [63:0] mag;
    logic [87:0] wide;
    real         d;
    real         lim;
    int          n;
    m   = width_mask(t);
    n   = 8 << t[1:0];
    mag = '0;
    if (b[30:23] == 8'hFF && b[22:0] != 0) return '0;
    d = $bitstoreal(single_to_double(b));
    if (b[30:23] >= 8'd127 && b[30:23] < 8'd191) begin
      wide = {64'd0, 1'b1, b[22:0]} << (b[30:23] - 8'd127);
      wide = wide >> 23;
      mag  = wide[63:0];
    end
    if (!t[2]) begin
      lim = 2.0 ** (n - 1);
      if (d >= lim) return m >> 1;
      if (d <= -lim - 1.0) return ~(m >> 1) & m;
      return (b[31] ? 64'd0 - mag : mag) & m;
    end
    lim = 2.0 ** n;
    if (d >= lim) return m;
    if (d < 1.0) return '0;
    return mag & m;
  endfunction

  // Expected result of one element under the current types
  function automatic out_item_t convert_element(logic [3:0] st, logic [3:0] dt, in_item_t it);
    out_item_t   r;
    longint      v;
    logic [63:0] dbits;
    r = '0;
    r.last_out = it.last_element;
    if (st == dt) begin
      if (st <= TypeC128) begin
        r.result_value = it.source_value & width_mask(st);
        if (st == TypeC128) r.result_high = it.source_high;
        r.written = 1'b1;
      end
    end else if (st == TypeI8 || st == TypeI16) begin
      v = (st == TypeI8) ? longint'($signed(it.source_value[7:0]))
                         : longint'($signed(it.source_value[15:0]));
      dbits = $realtobits(real'(v));
      r.written = 1'b1;
      if (dt < TypeF32) r.result_value = 64'(v) & width_mask(dt);
      else if (dt == TypeF32 || dt == TypeC64)
        r.result_value = (v == 0) ? 64'd0
                         : {32'd0, dbits[63], 8'(dbits[62:52] - 11'd896), dbits[51:29]};
      else if (dt == TypeF64 || dt == TypeC128) r.result_value = dbits;
      else r.written = 1'b0;
    end else if (st == TypeF32) begin
      r.written = 1'b1;
      if (dt < TypeF32) r.result_value = single_to_integer(it.source_value[31:0], dt);
      else if (dt == TypeF64 || dt == TypeC128)
        r.result_value = single_to_double(it.source_value[31:0]);
      else if (dt == TypeC64) r.result_value = {32'd0, it.source_value[31:0]};
      else r.written = 1'b0;
    end else if (st == TypeC64) begin
      r.written = 1'b1;
      if (dt == TypeF32) r.result_value = {32'd0, it.source_value[31:0]};
      else if (dt == TypeF64) r.result_value = single_to_double(it.source_value[31:0]);
      else if (dt == TypeC128) begin
        r.result_value = single_to_double(it.source_value[31:0]);
        r.result_high  = single_to_double(it.source_value[63:32]);
      end else r.written = 1'b0;
    end
    return r;
  endfunction

  // Track registers, predict on accept, compare on result
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      src_type <= TypeI8;
      dst_type <= TypeI8;
      expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegSourceType) src_type <= cfg_data_i;
        else dst_type <= cfg_data_i;
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(convert_element(src_type, dst_type, in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: value %h", out_data_i.result_value);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_item = expected_q.pop_front();
          checked_o <= checked_o + 1;
          if (exp_item !== out_data_i) fail_count_o <= fail_count_o + 1;
          if (exp_item.result_value !== out_data_i.result_value)
            $error("result_value: expected %h, got %h",
                   exp_item.result_value, out_data_i.result_value);
          if (exp_item.result_high !== out_data_i.result_high)
            $error("result_high: expected %h, got %h",
                   exp_item.result_high, out_data_i.result_high);
          if (exp_item.written !== out_data_i.written)
            $error("written: expected %b, got %b", exp_item.written, out_data_i.written);
          if (exp_item.last_out !== out_data_i.last_out)
            $error("last_out: expected %b, got %b", exp_item.last_out, out_data_i.last_out);
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

[dv/tb_numeric_type_cast_unit_core.sv]
`timescale 1ns / 1ps
// Testbench top for numeric_type_cast_unit_core: drives config and elements,
// stalls the output, and gives the verdict. Depends on ntcu_pkg, ntcu_stream_if, checker.
module tb_numeric_type_cast_unit_core;
  import ntcu_pkg::*;

  localparam int CycleLimit = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_data;
  int         fail_count;
  int         pending;
  int         checked;
  int         cycles = 0;
  int         sent = 0;
  int         phases = 0;
  int         burst_left = 0;

  ntcu_stream_if #(.T(in_item_t))  in_s ();
  ntcu_stream_if #(.T(out_item_t)) out_s ();

  numeric_type_cast_unit_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_s       (in_s),
    .out_s      (out_s)
  );

  ntcu_cast_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_s.valid),
    .in_ready_i  (in_s.ready),
    .in_data_i   (in_s.data),
    .out_valid_i (out_s.valid),
    .out_ready_i (out_s.ready),
    .out_data_i  (out_s.data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output stall pattern: ready always high, random, or mostly low, by a randomly drawn mode
  initial begin
    int mode;
    mode = 0;
    out_s.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_s.ready <= 1'b1;
        1: out_s.ready <= $urandom_range(0, 1);
        default: out_s.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Float32 pattern around the interesting ranges
  function automatic logic [31:0] pick_single();
    logic [7:0] ex;
    case ($urandom_range(0, 5))
      0: ex = 8'h00;
      1: ex = 8'hFF;
      2: ex = 8'($urandom_range(180, 200));
      3: ex = 8'($urandom_range(0, 255));
      default: ex = 8'($urandom_range(120, 160));
    endcase
    return {1'($urandom), ex, ($urandom_range(0, 3) == 0) ? 23'd0 : 23'($urandom)};
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom)};
      default: return pick_single();
    endcase
  endfunction

  // Drive one element and wait until it is taken
  task automatic push_element(logic [63:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_s.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_s.valid <= 1'b1;
    in_s.data  <= '{source_value: value, source_high: {$urandom, $urandom},
                   last_element: 1'($urandom)};
    @(posedge clk_i);
    while (!in_s.ready) @(posedge clk_i);
    sent++;
  endtask

  // Wait for the pipeline to drain, then set both types
  task automatic set_types(logic [3:0] st, logic [3:0] dt);
    in_s.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= RegSourceType;
    cfg_data  <= st;
    @(posedge clk_i);
    cfg_index <= RegDestType;
    cfg_data  <= dt;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    phases++;
  endtask

  initial begin
    logic [3:0] st;
    logic [3:0] dt;
    int         count;
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = RegSourceType;
    cfg_data   = '0;
    in_s.valid = 1'b0;
    in_s.data  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset types: int8 copy with extremes
    push_element(64'h0);
    push_element('1);
    // Float to int32: NaN, infinities, negative zero, out of range, fractions
    set_types(TypeF32, TypeI32);
    push_element(64'h7FC0_0001);
    push_element(64'h7F80_0000);
    push_element(64'hFF80_0000);
    push_element(64'h8000_0000);
    push_element(64'h4F00_0000);
    push_element(64'hCF00_0001);
    push_element(64'hBF7F_FFFF);
    // Float to unsigned: negative and top of range
    set_types(TypeF32, TypeU8);
    push_element(64'hC2C8_0000);
    push_element(64'h437F_8000);
    push_element(64'h4380_0000);
    // Float to int64 at the edge
    set_types(TypeF32, TypeI64);
    push_element(64'h5F00_0000);
    push_element(64'hDF00_0000);
    // Widening of NaN and subnormals
    set_types(TypeF32, TypeF64);
    push_element(64'hFF80_0123);
    push_element(64'h0000_0001);
    push_element(64'h807F_FFFF);
    // Integer extremes to float and complex
    set_types(TypeI16, TypeC64);
    push_element(64'h8000);
    push_element(64'h7FFF);
    set_types(TypeC64, TypeC128);
    push_element(64'h7FC0_0000_8000_0000);

    // Every pair, codes twelve to fifteen included
    for (int p = 0; p < 256; p++) begin
      st = 4'(p >> 4);
      dt = 4'(p);
      count = (st == TypeI8 || st == TypeI16 || st == TypeF32 || st == TypeC64 ||
               st == dt) ? 9 : 2;
      set_types(st, dt);
      for (int i = 0; i < count; i++) push_element({pick_word(), pick_word()});
    end
    // Pairs with a supported source again, chosen at random
    for (int p = 0; p < 120; p++) begin
      case ($urandom_range(0, 3))
        0: st = TypeI8;
        1: st = TypeI16;
        2: st = TypeF32;
        default: st = TypeC64;
      endcase
      dt = ($urandom_range(0, 7) == 0) ? st : 4'($urandom_range(0, 11));
      set_types(st, dt);
      for (int i = 0; i < 8; i++) push_element({pick_word(), pick_word()});
    end

    in_s.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d elements over %0d type settings, %0d results checked.",
             sent, phases, checked);
    $display("All 256 type pairs covered, float specials and integer extremes included.");
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
